// ===== src/pcr_pkg.sv =====
// Package for the prime range counter: field widths, sequencer states and
// the status group passed from the remainder unit to the sequencer.
// No dependencies.
package pcr_pkg;

  // Field widths fixed by the stream format
  localparam int FIELD_W        = 16;
  localparam int COUNT_W        = 16;
  localparam int VALUE_BITS_DEF = 16;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_TEST,
    S_WAIT,
    S_NEXT,
    S_DONE
  } seq_state_t;

  // Status from the remainder unit
  typedef struct packed {
    logic done;   // one-cycle pulse, remainder is final
    logic zero;   // remainder is zero (valid with done)
  } rem_status_t;

endpackage

// ===== src/pcr_rem_unit.sv =====
// Shared remainder unit: restoring division, one quotient bit per cycle.
// Depends on pcr_pkg for the status struct.
module pcr_rem_unit #(
  parameter int VAL_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VAL_W-1:0]    dividend,
  input  logic [VAL_W:0]      divisor,
  output pcr_pkg::rem_status_t status
);

  localparam int CW = $clog2(VAL_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [VAL_W:0]   rem_r, rem_nxt;
  logic [VAL_W:0]   div_r, div_nxt;
  logic [VAL_W-1:0] shf_r, shf_nxt;
  logic [VAL_W+1:0] trial;

  // One shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    shf_nxt  = shf_r;
    trial    = {rem_r, shf_r[VAL_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VAL_W);
      rem_nxt  = '0;
      div_nxt  = divisor;
      shf_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = (VAL_W+1)'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[VAL_W:0];
      end
      shf_nxt = {shf_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    shf_r <= shf_nxt;
  end

  assign status.done = done_r;
  assign status.zero = (rem_r == '0);

endmodule

// ===== src/pcr_seq.sv =====
// Sequencer: walks the candidates of a range and their trial divisors,
// driving the shared remainder unit. Depends on pcr_pkg and pcr_rem_unit.
module pcr_seq #(
  parameter int VAL_W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [VAL_W-1:0]            lo,
  input  logic [VAL_W-1:0]            hi,
  input  logic                        res_free,
  output logic                        idle,
  output logic                        done,
  output logic [pcr_pkg::COUNT_W-1:0] count
);

  localparam int CNT_W = pcr_pkg::COUNT_W;

  pcr_pkg::seq_state_t state_r, state_nxt;
  logic [VAL_W-1:0]   n_r, n_nxt;
  logic [VAL_W-1:0]   hi_r, hi_nxt;
  logic [VAL_W:0]     d_r, d_nxt;
  logic [VAL_W+1:0]   sq_r, sq_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rem_start;
  pcr_pkg::rem_status_t rem_st;

  pcr_rem_unit #(.VAL_W(VAL_W)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (n_r),
    .divisor  (d_r),
    .status   (rem_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    hi_r  <= hi_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    cnt_r <= cnt_nxt;
  end

  // Next state: candidate loop with inner divisor loop up to sqrt(n)
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    hi_nxt    = hi_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    cnt_nxt   = cnt_r;
    rem_start = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      pcr_pkg::S_IDLE: begin
        if (start) begin
          n_nxt   = lo;
          hi_nxt  = hi;
          cnt_nxt = '0;
          state_nxt = (lo > hi) ? pcr_pkg::S_DONE : pcr_pkg::S_CAND;
        end
      end
      pcr_pkg::S_CAND: begin
        // 0 and 1 are never prime
        if (n_r < VAL_W'(2)) begin
          state_nxt = pcr_pkg::S_NEXT;
        end else begin
          d_nxt     = (VAL_W+1)'(2);
          sq_nxt    = (VAL_W+2)'(4);
          state_nxt = pcr_pkg::S_TEST;
        end
      end
      pcr_pkg::S_TEST: begin
        // no divisor up to sqrt(n) divides it: prime
        if (sq_r > {2'b00, n_r}) begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = pcr_pkg::S_NEXT;
        end else begin
          rem_start = 1'b1;
          state_nxt = pcr_pkg::S_WAIT;
        end
      end
      pcr_pkg::S_WAIT: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            state_nxt = pcr_pkg::S_NEXT;
          end else begin
            // 2 -> 3, then odd divisors only; square tracked incrementally
            if (d_r == (VAL_W+1)'(2)) begin
              d_nxt  = (VAL_W+1)'(3);
              sq_nxt = (VAL_W+2)'(9);
            end else begin
              d_nxt  = d_r + (VAL_W+1)'(2);
              sq_nxt = sq_r + {d_r, 1'b0} + {d_r, 1'b0} + (VAL_W+2)'(4);
            end
            state_nxt = pcr_pkg::S_TEST;
          end
        end
      end
      pcr_pkg::S_NEXT: begin
        if (n_r == hi_r) begin
          state_nxt = pcr_pkg::S_DONE;
        end else begin
          n_nxt     = n_r + VAL_W'(1);
          state_nxt = pcr_pkg::S_CAND;
        end
      end
      pcr_pkg::S_DONE: begin
        if (res_free) begin
          done      = 1'b1;
          state_nxt = pcr_pkg::S_IDLE;
        end
      end
      default: state_nxt = pcr_pkg::S_IDLE;
    endcase
  end

  assign idle  = (state_r == pcr_pkg::S_IDLE);
  assign count = cnt_r;

endmodule

// ===== src/prime_count_in_range.sv =====
// Top level of the prime range counter: stream ports and result register.
// Depends on pcr_pkg and pcr_seq (which holds pcr_rem_unit).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in      | in  | in_tvalid/tready   | in_tdata: range_low, range_high
//  out     | out | out_tvalid/tready  | out_tdata: prime_count
//
// Each candidate is tested by trial division with 2, then with odd values
// while d*d <= n, on the bit-serial remainder unit that all divisions
// share. An empty range is finished without testing any candidate.
// in_tready is high only while the sequencer is idle. The result waits in
// an output register; a stalled output holds the sequencer at its end.
// Reset is synchronous, active low, and returns the sequencer to idle.
module prime_count_in_range #(
  parameter int VALUE_BITS = pcr_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] range_low, [31:16] range_high
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] prime_count
);

  localparam int FW    = pcr_pkg::FIELD_W;
  localparam int VAL_W = (VALUE_BITS < FW) ? VALUE_BITS : FW;

  logic                        seq_idle;
  logic                        seq_done;
  logic [pcr_pkg::COUNT_W-1:0] seq_count;
  logic                        out_valid_r;
  logic [pcr_pkg::COUNT_W-1:0] out_data_r;
  logic                        res_free;
  logic                        in_acc;

  assign in_tready = seq_idle;
  assign in_acc    = in_tvalid && seq_idle;
  assign res_free  = !out_valid_r || out_tready;

  // Bounds are masked to the value width
  pcr_seq #(.VAL_W(VAL_W)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .lo       (in_tdata[VAL_W-1:0]),
    .hi       (in_tdata[FW+VAL_W-1:FW]),
    .res_free (res_free),
    .idle     (seq_idle),
    .done     (seq_done),
    .count    (seq_count)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_data_r <= seq_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for prime_count_in_range: drives range requests on the
// input stream, predicts each prime count from a sieve table and checks results.
// Depends on pcr_pkg and the prime_count_in_range RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIELD_W      = pcr_pkg::FIELD_W;
  localparam int COUNT_W      = pcr_pkg::COUNT_W;
  localparam int VALUE_BITS   = pcr_pkg::VALUE_BITS_DEF;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 580;
  localparam int CALM_ITEMS   = 80;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AFTER   = 40;
  localparam int DRAIN_CYCLES = 64;
  localparam int SPAN         = 1 << FIELD_W;

  // Sieve-based prime count predictor and store of pending counts
  class prime_scoreboard;
    typedef struct {
      logic [FIELD_W-1:0] range_low;
      logic [FIELD_W-1:0] range_high;
      logic [COUNT_W-1:0] prime_count;
    } count_expect_t;

    bit          is_composite[SPAN];
    int unsigned primes_below[SPAN+1];
    count_expect_t expected_counts[$];
    int          num_checked;
    int          num_errors;

    function new();
      int unsigned v;
      int unsigned m;
      int unsigned running;
      running = 0;
      num_checked = 0;
      num_errors = 0;
      foreach (is_composite[i]) is_composite[i] = 1'b0;
      is_composite[0] = 1'b1;
      is_composite[1] = 1'b1;
      for (v = 2; v * v < SPAN; v++) begin
        if (!is_composite[v]) begin
          for (m = v * v; m < SPAN; m += v) is_composite[m] = 1'b1;
        end
      end
      for (v = 0; v < SPAN; v++) begin
        primes_below[v] = running;
        if (!is_composite[v]) running++;
      end
      primes_below[SPAN] = running;
    endfunction

    // Bounds are cut to VALUE_BITS; an empty range holds no primes
    function logic [COUNT_W-1:0] count_in_range(logic [FIELD_W-1:0] lo,
                                                logic [FIELD_W-1:0] hi);
      longint unsigned keep;
      int unsigned a;
      int unsigned b;
      keep = (64'd1 << VALUE_BITS) - 1;
      a = int'(lo & keep);
      b = int'(hi & keep);
      if (a > b) return '0;
      return COUNT_W'(primes_below[b+1] - primes_below[a]);
    endfunction

    function void note_range(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
      count_expect_t e;
      e.range_low   = lo;
      e.range_high  = hi;
      e.prime_count = count_in_range(lo, hi);
      expected_counts.push_back(e);
    endfunction

    function void check_count(logic [COUNT_W-1:0] actual);
      count_expect_t e;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
        num_errors++;
        return;
      end
      e = expected_counts.pop_front();
      num_checked++;
      if (actual !== e.prime_count) begin
        $display("%0t: prime_count mismatch for [%0d,%0d]: expected %0d, actual %0d",
                 $time, e.range_low, e.range_high, e.prime_count, actual);
        num_errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [15:0] range_low, [31:16] range_high
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] prime_count

  prime_scoreboard sb = new();
  bit calm = 1'b0;
  int ranges_sent   = 0;
  int empty_ranges  = 0;
  int single_values = 0;

  always #2 clk = ~clk;

  prime_count_in_range #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Offer one request and hold it until accepted; valid stays high afterwards
  task automatic send_range(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_range(lo, hi);
    ranges_sent++;
    if (lo > hi) empty_ranges++;
    if (lo == hi) single_values++;
  endtask

  // Result side: check accepted counts, stall in bursts, one long hold-off
  initial begin
    int stall_left;
    int hold_left;
    bit pressure_done;
    stall_left = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) sb.check_count(out_tdata);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!pressure_done && sb.num_checked >= HOLD_AFTER) begin
        // input keeps offering while the result register stays full
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Request side: directed corners, then random ranges kept short
  initial begin
    int unsigned lo_v;
    int unsigned hi_v;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single values at the low end, squares, small spans
    send_range(16'd0, 16'd0);
    send_range(16'd1, 16'd1);
    send_range(16'd2, 16'd2);
    send_range(16'd3, 16'd3);
    send_range(16'd4, 16'd4);
    send_range(16'd9, 16'd9);
    send_range(16'd25, 16'd25);
    send_range(16'd0, 16'd1);
    send_range(16'd0, 16'd2);
    send_range(16'd0, 16'd100);
    // empty ranges
    send_range(16'd3, 16'd2);
    send_range(16'd65535, 16'd0);
    send_range(16'd65535, 16'd65534);
    // top of the value range, largest 16-bit prime
    send_range(16'd65535, 16'd65535);
    send_range(16'd65521, 16'd65521);
    send_range(16'd65534, 16'd65535);
    send_range(16'd65520, 16'd65535);
    // wider spans and alternating bit patterns
    send_range(16'd0, 16'd1000);
    send_range(16'd65000, 16'd65100);
    send_range(16'd43690, 16'd43700);
    send_range(16'd21845, 16'd21850);
    send_range(16'd32767, 16'd32771);
    send_range(16'd32768, 16'd32768);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          lo_v = $urandom_range(0, 300);
          hi_v = lo_v + $urandom_range(0, 24);
        end
        4, 5, 6: begin
          // anywhere in the field, only a few candidates
          lo_v = $urandom_range(0, 65535);
          hi_v = lo_v + $urandom_range(0, 3);
        end
        7, 8: begin
          hi_v = $urandom_range(0, 65534);
          lo_v = $urandom_range(hi_v + 1, 65535);
        end
        default: begin
          lo_v = $urandom_range(0, 1000);
          hi_v = lo_v + $urandom_range(0, 40);
        end
      endcase
      if (hi_v > 65535) hi_v = 65535;
      send_range(lo_v[FIELD_W-1:0], hi_v[FIELD_W-1:0]);
    end
    in_tvalid <= 1'b0;

    while (sb.expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ranges: %0d empty, %0d single values, rest spans up to 1001",
             ranges_sent, empty_ranges, single_values);
    $display("Checked %0d prime counts, %0d errors", sb.num_checked, sb.num_errors);
    if (sb.num_errors == 0 && sb.expected_counts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #80_000_000;
    $display("Timeout with %0d counts outstanding", sb.expected_counts.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
src/pcr_pkg.sv
src/pcr_rem_unit.sv
src/pcr_seq.sv
src/prime_count_in_range.sv
bench/tb_top.sv
